[rtl/itc_pkg.sv]
// Shared types, codes and lookup functions for the interrupt and timer controller.
// No dependencies.
package itc_pkg;

  localparam int unsigned GroupW = 16;

  typedef enum logic [3:0] {
    ACT_TICK       = 4'd0,
    ACT_VBLANK_IN  = 4'd1,
    ACT_VBLANK_OUT = 4'd2,
    ACT_HBLANK_IN  = 4'd3,
    ACT_DSP_END    = 4'd4,
    ACT_SOUND      = 4'd5,
    ACT_SYSMGR     = 4'd6,
    ACT_DMA_END    = 4'd7,
    ACT_SPRITE_END = 4'd8,
    ACT_EXT0       = 4'd9,
    ACT_ACK        = 4'd10
  } itc_action_e;

  typedef enum logic [2:0] {
    REG_IRQ_MASK  = 3'd0,
    REG_T0_CMP    = 3'd1,
    REG_T1_RELOAD = 3'd2,
    REG_T1_EN     = 3'd3,
    REG_T1_MODE   = 3'd4
  } itc_reg_e;

  // pending bit positions
  localparam int unsigned PbVblankIn  = 0;
  localparam int unsigned PbVblankOut = 1;
  localparam int unsigned PbHblankIn  = 2;
  localparam int unsigned PbTimer0    = 3;
  localparam int unsigned PbTimer1    = 4;
  localparam int unsigned PbDspEnd    = 5;
  localparam int unsigned PbSound     = 6;
  localparam int unsigned PbSysmgr    = 7;
  localparam int unsigned PbDma2End   = 9;
  localparam int unsigned PbDma1End   = 10;
  localparam int unsigned PbDma0End   = 11;
  localparam int unsigned PbSprEnd    = 13;
  localparam int unsigned PbExt0      = 16;

  // DMA trigger bit positions
  localparam int unsigned TrVblankIn  = 0;
  localparam int unsigned TrVblankOut = 1;
  localparam int unsigned TrHblankIn  = 2;
  localparam int unsigned TrTimer0    = 3;
  localparam int unsigned TrTimer1    = 4;
  localparam int unsigned TrSound     = 5;
  localparam int unsigned TrSprEnd    = 6;

  localparam logic [6:0] LowVecBase  = 7'h40;
  localparam logic [6:0] HighVecBase = 7'h50;

  typedef struct packed {
    logic [15:0] mask;
    logic [9:0]  t0_cmp;
    logic [8:0]  t1_reload;
    logic        t1_en;
    logic        t1_mode;
  } itc_cfg_t;

  typedef struct packed {
    logic [31:0] pending;
    logic [9:0]  line;
    logic [8:0]  down;
  } itc_state_t;

  typedef struct packed {
    logic [3:0]  action;
    logic [15:0] tick;
    logic        snd;
    logic [1:0]  dlev;
  } itc_item_t;

  typedef struct packed {
    logic [3:0]  level;
    logic [6:0]  vector;
    logic [31:0] pending;
    logic [6:0]  trig;
  } itc_result_t;

  // index of lowest set bit, 16 when none
  function automatic logic [4:0] lowest_set16(input logic [GroupW-1:0] v);
    logic [4:0] idx;
    idx = 5'd16;
    for (int i = GroupW - 1; i >= 0; i--) begin
      if (v[i]) idx = 5'(i);
    end
    return idx;
  endfunction

  function automatic logic [3:0] low_level(input logic [4:0] idx);
    logic [3:0] lvl;
    case (idx)
      5'd0:    lvl = 4'hF;
      5'd1:    lvl = 4'hE;
      5'd2:    lvl = 4'hD;
      5'd3:    lvl = 4'hC;
      5'd4:    lvl = 4'hB;
      5'd5:    lvl = 4'hA;
      5'd6:    lvl = 4'h9;
      5'd7:    lvl = 4'h8;
      5'd8:    lvl = 4'h8;
      5'd9:    lvl = 4'h6;
      5'd10:   lvl = 4'h6;
      5'd11:   lvl = 4'h5;
      5'd12:   lvl = 4'h3;
      5'd13:   lvl = 4'h2;
      default: lvl = 4'h0;
    endcase
    return lvl;
  endfunction

  function automatic logic [3:0] high_level(input logic [4:0] idx);
    logic [3:0] lvl;
    case (idx) inside
      [5'd0:5'd3]:  lvl = 4'h7;
      [5'd4:5'd7]:  lvl = 4'h4;
      [5'd8:5'd15]: lvl = 4'h1;
      default:      lvl = 4'h0;
    endcase
    return lvl;
  endfunction

endpackage

[rtl/itc_eval.sv]
// Next-state and result logic for one event of the interrupt and timer controller.
// Depends on itc_pkg.
module itc_eval (
  input  itc_pkg::itc_cfg_t    cfg_i,
  input  itc_pkg::itc_state_t  state_i,
  input  itc_pkg::itc_item_t   item_i,
  output itc_pkg::itc_state_t  state_o,
  output itc_pkg::itc_result_t result_o
);
  import itc_pkg::*;

  logic [31:0] pend;
  logic [9:0]  line;
  logic [8:0]  down;
  logic [6:0]  trig;
  logic [31:0] active;
  logic [4:0]  lo;
  logic [4:0]  hi;
  logic [3:0]  lo_lvl;
  logic [3:0]  hi_lvl;
  logic        low_wins;
  logic [15:0] clr_lo;
  logic [15:0] clr_hi;
  logic [3:0]  level;
  logic [6:0]  vector;

  always_comb begin
    pend = state_i.pending;
    line = state_i.line;
    down = state_i.down;
    trig = '0;

    unique case (item_i.action)
      ACT_TICK: begin
        if (item_i.tick >= 16'(down)) begin
          down = '0;
          if (cfg_i.t1_en && (!cfg_i.t1_mode || line == cfg_i.t0_cmp)) begin
            pend[PbTimer1] = 1'b1;
            trig[TrTimer1] = 1'b1;
          end
        end else begin
          down = down - item_i.tick[8:0];
        end
      end
      ACT_VBLANK_IN: begin
        pend[PbVblankIn] = 1'b1;
        trig[TrVblankIn] = 1'b1;
      end
      ACT_VBLANK_OUT: begin
        pend[PbVblankOut] = 1'b1;
        line = '0;
        trig[TrVblankOut] = 1'b1;
      end
      ACT_HBLANK_IN: begin
        pend[PbHblankIn] = 1'b1;
        line = line + 10'd1;
        if (line == cfg_i.t0_cmp) begin
          pend[PbTimer0] = 1'b1;
          trig[TrTimer0] = 1'b1;
        end
        down = cfg_i.t1_reload;
        trig[TrHblankIn] = 1'b1;
      end
      ACT_DSP_END: pend[PbDspEnd] = 1'b1;
      ACT_SOUND: begin
        pend[PbSound] = item_i.snd;
        trig[TrSound] = 1'b1;
      end
      ACT_SYSMGR: pend[PbSysmgr] = 1'b1;
      ACT_DMA_END: begin
        case (item_i.dlev)
          2'd0:    pend[PbDma0End] = 1'b1;
          2'd1:    pend[PbDma1End] = 1'b1;
          2'd2:    pend[PbDma2End] = 1'b1;
          default: ;
        endcase
        trig[TrSprEnd] = 1'b1;
      end
      ACT_SPRITE_END: begin
        pend[PbSprEnd] = 1'b1;
        trig[TrSprEnd] = 1'b1;
      end
      ACT_EXT0: pend[PbExt0] = 1'b1;
      default: ;
    endcase

    active   = pend & ~{16'h0000, cfg_i.mask};
    lo       = lowest_set16(active[15:0]);
    hi       = lowest_set16(active[31:16]);
    lo_lvl   = low_level(lo);
    hi_lvl   = high_level(hi);
    low_wins = lo_lvl >= hi_lvl;

    level  = '0;
    vector = '0;
    clr_lo = '0;
    clr_hi = '0;
    if (active != '0) begin
      if (item_i.action == ACT_ACK) begin
        if (low_wins) begin
          if (!lo[4]) clr_lo[lo[3:0]] = 1'b1;
        end else if (!hi[4]) begin
          clr_hi[hi[3:0]] = 1'b1;
        end
      end else if (low_wins) begin
        level  = lo_lvl;
        vector = LowVecBase + 7'(lo[3:0]);
      end else begin
        level  = hi_lvl;
        vector = HighVecBase + 7'(hi[3:0]);
      end
    end
    pend = pend & ~{clr_hi, clr_lo};

    state_o.pending  = pend;
    state_o.line     = line;
    state_o.down     = down;
    result_o.level   = level;
    result_o.vector  = vector;
    result_o.pending = pend;
    result_o.trig    = trig;
  end

endmodule

[rtl/interrupt_timer_controller_unit.sv]
// Top level of the interrupt and timer controller: input register, state, result register.
// Depends on itc_pkg and itc_eval.
// An event passes from the input register to the result register before its result transfer.
// Throughput: one event per cycle while the output is not stalled; state update and priority encode are combinational.
// While a result waits under stall, the input register can still take one event; more input then stalls.
// Reset clears pending bits, both timers, all config registers and both valid flags.
module interrupt_timer_controller_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [3:0]  action_i,
  input  logic [15:0] tick_cycles_i,
  input  logic        sound_level_i,
  input  logic [1:0]  dma_level_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [3:0]  irq_level_o,
  output logic [6:0]  irq_vector_o,
  output logic [31:0] pending_bits_o,
  output logic [6:0]  dma_triggers_o,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [15:0] cfg_wdata_i
);
  import itc_pkg::*;

  itc_cfg_t    cfg_q;
  itc_state_t  state_q;
  itc_state_t  state_d;
  itc_item_t   item_q;
  itc_result_t res_q;
  itc_result_t res_d;
  logic        s1_valid_q;
  logic        out_valid_q;
  logic        advance;
  logic        in_xfer;

  assign advance    = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = s1_valid_q && !advance;
  assign in_xfer    = in_valid_i && !in_stall_o;

  itc_eval u_eval (
    .cfg_i    (cfg_q),
    .state_i  (state_q),
    .item_i   (item_q),
    .state_o  (state_d),
    .result_o (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_IRQ_MASK:  cfg_q.mask      <= cfg_wdata_i;
        REG_T0_CMP:    cfg_q.t0_cmp    <= cfg_wdata_i[9:0];
        REG_T1_RELOAD: cfg_q.t1_reload <= cfg_wdata_i[8:0];
        REG_T1_EN:     cfg_q.t1_en     <= cfg_wdata_i[0];
        REG_T1_MODE:   cfg_q.t1_mode   <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= '0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (advance) state_q <= state_d;
      if (in_xfer) begin
        s1_valid_q <= 1'b1;
      end else if (advance) begin
        s1_valid_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      item_q.action <= action_i;
      item_q.tick   <= tick_cycles_i;
      item_q.snd    <= sound_level_i;
      item_q.dlev   <= dma_level_i;
    end
    if (advance) res_q <= res_d;
  end

  assign out_valid_o    = out_valid_q;
  assign irq_level_o    = res_q.level;
  assign irq_vector_o   = res_q.vector;
  assign pending_bits_o = res_q.pending;
  assign dma_triggers_o = res_q.trig;

  a_ack_no_request: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && item_q.action == ACT_ACK |=> irq_level_o == '0 && irq_vector_o == '0)
    else $error("acknowledge result carries a request");

  a_level_has_vector: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && irq_level_o != '0 |-> irq_vector_o != '0 && pending_bits_o != '0)
    else $error("request level without vector or pending bit");

  a_line_changes_on_blank: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.line != $past(state_q.line) |->
      $past(advance && (item_q.action == ACT_HBLANK_IN || item_q.action == ACT_VBLANK_OUT)))
    else $error("line counter moved without a blank event");

  a_timer1_needs_enable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && dma_triggers_o[TrTimer1] |-> cfg_q.t1_en)
    else $error("timer1 trigger while disabled");

endmodule

[bench/interrupt_timer_controller_unit_tb.sv]
// Testbench for interrupt_timer_controller_unit: directed and random event streams,
// checked transfer by transfer against a built-in prediction of the controller.
// Depends on itc_pkg and the controller RTL.
module interrupt_timer_controller_unit_tb;
  import itc_pkg::*;

  localparam int unsigned CycleLimit = 400000;
  localparam logic [3:0]  ActUnused  = 4'd15;
  localparam logic [2:0]  RegUnused  = 3'd7;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [3:0]  action_i = '0;
  logic [15:0] tick_cycles_i = '0;
  logic        sound_level_i = 1'b0;
  logic [1:0]  dma_level_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [3:0]  irq_level_o;
  logic [6:0]  irq_vector_o;
  logic [31:0] pending_bits_o;
  logic [6:0]  dma_triggers_o;
  logic        cfg_we_i = 1'b0;
  logic [2:0]  cfg_index_i = '0;
  logic [15:0] cfg_wdata_i = '0;

  interrupt_timer_controller_unit uut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_stall_o(in_stall_o),
    .action_i(action_i), .tick_cycles_i(tick_cycles_i),
    .sound_level_i(sound_level_i), .dma_level_i(dma_level_i),
    .out_valid_o(out_valid_o), .out_stall_i(out_stall_i),
    .irq_level_o(irq_level_o), .irq_vector_o(irq_vector_o),
    .pending_bits_o(pending_bits_o), .dma_triggers_o(dma_triggers_o),
    .cfg_we_i(cfg_we_i), .cfg_index_i(cfg_index_i), .cfg_wdata_i(cfg_wdata_i)
  );

  // controller shadow: configuration and state
  logic [15:0] irq_mask = '0;
  logic [9:0]  t0_compare = '0;
  logic [8:0]  t1_reload = '0;
  logic        t1_enable = 1'b0;
  logic        t1_mode = 1'b0;
  logic [31:0] pending = '0;
  logic [9:0]  line_cnt = '0;
  logic [8:0]  down_cnt = '0;

  logic [3:0] low_lvl_tab [0:16] = '{4'hF, 4'hE, 4'hD, 4'hC, 4'hB, 4'hA, 4'h9, 4'h8,
                                     4'h8, 4'h6, 4'h6, 4'h5, 4'h3, 4'h2, 4'h0, 4'h0, 4'h0};
  logic [3:0] high_lvl_tab [0:16] = '{4'h7, 4'h7, 4'h7, 4'h7, 4'h4, 4'h4, 4'h4, 4'h4,
                                      4'h1, 4'h1, 4'h1, 4'h1, 4'h1, 4'h1, 4'h1, 4'h1, 4'h0};

  itc_item_t   event_q [$];
  itc_result_t expected_irq_q [$];
  int          n_events = 0;
  int          mismatches = 0;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  int unsigned cycle_cnt = 0;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic int first_set(input logic [15:0] v);
    int idx;
    idx = 16;
    for (int i = 15; i >= 0; i--) begin
      if (v[i]) idx = i;
    end
    return idx;
  endfunction

  function automatic itc_result_t advance_controller(input itc_item_t ev);
    itc_result_t r;
    logic [31:0] active;
    int lo, hi;
    logic [3:0] lo_lvl, hi_lvl;
    r = '0;
    case (ev.action)
      ACT_TICK: begin
        if ({7'd0, down_cnt} <= ev.tick) begin
          down_cnt = '0;
          if (t1_enable && (!t1_mode || line_cnt == t0_compare)) begin
            pending[PbTimer1] = 1'b1;
            r.trig[TrTimer1] = 1'b1;
          end
        end else begin
          down_cnt = down_cnt - ev.tick[8:0];
        end
      end
      ACT_VBLANK_IN: begin
        pending[PbVblankIn] = 1'b1;
        r.trig[TrVblankIn] = 1'b1;
      end
      ACT_VBLANK_OUT: begin
        pending[PbVblankOut] = 1'b1;
        line_cnt = '0;
        r.trig[TrVblankOut] = 1'b1;
      end
      ACT_HBLANK_IN: begin
        pending[PbHblankIn] = 1'b1;
        line_cnt = line_cnt + 10'd1;
        if (line_cnt == t0_compare) begin
          pending[PbTimer0] = 1'b1;
          r.trig[TrTimer0] = 1'b1;
        end
        down_cnt = t1_reload;
        r.trig[TrHblankIn] = 1'b1;
      end
      ACT_DSP_END: pending[PbDspEnd] = 1'b1;
      ACT_SOUND: begin
        pending[PbSound] = ev.snd;
        r.trig[TrSound] = 1'b1;
      end
      ACT_SYSMGR: pending[PbSysmgr] = 1'b1;
      ACT_DMA_END: begin
        case (ev.dlev)
          2'd0: pending[PbDma0End] = 1'b1;
          2'd1: pending[PbDma1End] = 1'b1;
          2'd2: pending[PbDma2End] = 1'b1;
          default: ;
        endcase
        r.trig[TrSprEnd] = 1'b1;
      end
      ACT_SPRITE_END: begin
        pending[PbSprEnd] = 1'b1;
        r.trig[TrSprEnd] = 1'b1;
      end
      ACT_EXT0: pending[PbExt0] = 1'b1;
      default: ;
    endcase

    active = pending & ~{16'h0000, irq_mask};
    if (active != '0) begin
      lo = first_set(active[15:0]);
      hi = first_set(active[31:16]);
      lo_lvl = low_lvl_tab[lo];
      hi_lvl = high_lvl_tab[hi];
      if (ev.action == ACT_ACK) begin
        if (lo_lvl >= hi_lvl) begin
          if (lo < 16) pending[lo] = 1'b0;
        end else begin
          pending[hi + 16] = 1'b0;
        end
      end else if (lo_lvl >= hi_lvl) begin
        r.level = lo_lvl;
        r.vector = LowVecBase + 7'(lo);
      end else begin
        r.level = hi_lvl;
        r.vector = HighVecBase + 7'(hi);
      end
    end
    r.pending = pending;
    return r;
  endfunction

  task automatic add_event(input logic [3:0] act, input logic [15:0] cyc,
                           input logic snd, input logic [1:0] dlev);
    itc_item_t ev;
    ev.action = act;
    ev.tick = cyc;
    ev.snd = snd;
    ev.dlev = dlev;
    event_q.push_back(ev);
    n_events++;
  endtask

  task automatic add_random_event(input bit keep_lines);
    int r;
    logic [3:0] act;
    logic [15:0] cyc;
    r = $urandom_range(0, 99);
    cyc = ($urandom_range(0, 4) == 0) ? 16'($urandom) : 16'($urandom_range(0, 64));
    if (r < 30) act = ACT_TICK;
    else if (r < 45) act = ACT_ACK;
    else if (r < 55) act = ACT_HBLANK_IN;
    else if (r < 60) act = ACT_VBLANK_IN;
    else if (r < 63 && !keep_lines) act = ACT_VBLANK_OUT;
    else if (r < 88) act = 4'($urandom_range(ACT_DSP_END, ACT_EXT0));
    else begin
      act = 4'($urandom_range(0, 15));
      if (keep_lines && act == ACT_VBLANK_OUT) act = ActUnused;
    end
    add_event(act, cyc, 1'($urandom), 2'($urandom));
  endtask

  // frames: vblank end, a run of lines with events between, then mostly vblank start; some slots get one random event
  task automatic add_frames(input int n);
    int target;
    int lines;
    target = n_events + n;
    while (n_events < target) begin
      if ($urandom_range(0, 9) == 0) begin
        add_random_event(1'b0);
      end else begin
        add_event(ACT_VBLANK_OUT, 16'($urandom), 1'($urandom), 2'($urandom));
        lines = $urandom_range(1, 12);
        repeat (lines) begin
          add_event(ACT_HBLANK_IN, 16'($urandom), 1'($urandom), 2'($urandom));
          repeat ($urandom_range(0, 3)) add_random_event(1'b1);
        end
        if ($urandom_range(0, 4) != 0)
          add_event(ACT_VBLANK_IN, 16'($urandom), 1'($urandom), 2'($urandom));
      end
    end
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [15:0] data);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= data;
    case (idx)
      REG_IRQ_MASK:  irq_mask = data;
      REG_T0_CMP:    t0_compare = data[9:0];
      REG_T1_RELOAD: t1_reload = data[8:0];
      REG_T1_EN:     t1_enable = data[0];
      REG_T1_MODE:   t1_mode = data[0];
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic apply_config(input logic [15:0] mask, input logic [15:0] cmp,
                              input logic [15:0] reload, input logic [15:0] en,
                              input logic [15:0] mode);
    write_reg(REG_IRQ_MASK, mask);
    write_reg(REG_T0_CMP, cmp);
    write_reg(REG_T1_RELOAD, reload);
    write_reg(REG_T1_EN, en);
    write_reg(REG_T1_MODE, mode);
  endtask

  task automatic drain();
    while (event_q.size() != 0 || in_valid_i || expected_irq_q.size() != 0)
      @(posedge clk_i);
  endtask

  task automatic check_field(input string fname, input logic [31:0] exp_v,
                             input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch in %s: expected %0h, actual %0h", fname, exp_v, act_v);
    end
  endtask

  // driver: predict on transfer, then present the next event
  always @(posedge clk_i) begin : driver
    itc_item_t ev;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o)
        expected_irq_q.push_back(advance_controller(
          itc_item_t'({action_i, tick_cycles_i, sound_level_i, dma_level_i})));
      if (!in_valid_i || !in_stall_o) begin
        if (event_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          ev = event_q.pop_front();
          action_i <= ev.action;
          tick_cycles_i <= ev.tick;
          sound_level_i <= ev.snd;
          dma_level_i <= ev.dlev;
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // monitor: compare each transfer with the oldest prediction
  always @(posedge clk_i) begin : monitor
    itc_result_t exp_r;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_irq_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result transfer");
        end else begin
          exp_r = expected_irq_q.pop_front();
          check_field("irq_level", 32'(exp_r.level), 32'(irq_level_o));
          check_field("irq_vector", 32'(exp_r.vector), 32'(irq_vector_o));
          check_field("pending_bits", exp_r.pending, pending_bits_o);
          check_field("dma_triggers", 32'(exp_r.trig), 32'(dma_triggers_o));
        end
      end
      out_stall_i <= ($urandom_range(0, 99) < recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt == CycleLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed events
    apply_config(16'h0000, 16'd2, 16'd5, 16'd1, 16'd0);
    add_event(ACT_ACK, 16'h0000, 1'b0, 2'd0);
    add_event(ActUnused, 16'hFFFF, 1'b1, 2'd3);
    add_event(ACT_TICK, 16'h0000, 1'b0, 2'd0);
    add_event(ACT_VBLANK_OUT, 16'h0000, 1'b0, 2'd0);
    add_event(ACT_VBLANK_IN, 16'h0000, 1'b0, 2'd0);
    add_event(ACT_HBLANK_IN, 16'h0000, 1'b0, 2'd0);
    add_event(ACT_TICK, 16'd3, 1'b0, 2'd0);
    add_event(ACT_TICK, 16'hFFFF, 1'b0, 2'd0);
    add_event(ACT_HBLANK_IN, 16'h0000, 1'b0, 2'd0);
    add_event(ACT_DSP_END, 16'h0000, 1'b0, 2'd0);
    add_event(ACT_SOUND, 16'h0000, 1'b1, 2'd0);
    add_event(ACT_SOUND, 16'hFFFF, 1'b0, 2'd3);
    add_event(ACT_SYSMGR, 16'h0000, 1'b0, 2'd0);
    add_event(ACT_DMA_END, 16'h0000, 1'b0, 2'd0);
    add_event(ACT_DMA_END, 16'h0000, 1'b0, 2'd1);
    add_event(ACT_DMA_END, 16'h0000, 1'b0, 2'd2);
    add_event(ACT_DMA_END, 16'h0000, 1'b0, 2'd3);
    add_event(ACT_SPRITE_END, 16'h0000, 1'b0, 2'd0);
    add_event(ACT_EXT0, 16'h0000, 1'b0, 2'd0);
    repeat (6) add_event(ACT_ACK, 16'hFFFF, 1'b1, 2'd3);
    drain();

    // long frame: line counter reaches the top compare value and wraps
    apply_config(16'h0000, 16'd1023, 16'd511, 16'd1, 16'd1);
    add_event(ACT_VBLANK_OUT, 16'($urandom), 1'($urandom), 2'($urandom));
    for (int ln = 1; ln <= 1030; ln++) begin
      add_event(ACT_HBLANK_IN, 16'($urandom), 1'($urandom), 2'($urandom));
      if (ln >= 1020 && ln <= 1026)
        add_event(ACT_TICK, 16'($urandom_range(400, 65535)), 1'($urandom), 2'($urandom));
      else if ($urandom_range(0, 15) == 0)
        add_random_event(1'b1);
    end
    drain();

    apply_config(16'hFFFF, 16'd0, 16'd0, 16'd1, 16'd0);
    send_idle_pct = 50;
    recv_stall_pct = 0;
    add_frames(30);
    drain();

    apply_config(16'($urandom & $urandom), 16'($urandom_range(0, 15)),
                 16'($urandom_range(0, 40)), 16'd1, 16'd1);
    send_idle_pct = 0;
    recv_stall_pct = 50;
    add_frames(30);
    drain();

    apply_config(16'($urandom & $urandom), 16'($urandom_range(0, 7)),
                 16'($urandom_range(1, 300)), 16'd0, 16'd0);
    write_reg(RegUnused, 16'($urandom));
    send_idle_pct = 13;
    recv_stall_pct = 13;
    add_frames(30);
    drain();

    apply_config(16'($urandom & $urandom), 16'($urandom_range(0, 15)),
                 16'($urandom_range(0, 40)), 16'd1, 16'd0);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    add_frames(30);
    drain();

    repeat (10) @(posedge clk_i);
    if (mismatches == 0 && expected_irq_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
